// ===== rtl/vtpd_pkg.sv =====
// shared constants, types and the divider step for the vertex transform core
// no dependencies
package vtpd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_DATA_W = 136;
    localparam int OUT_DATA_W = 96;
    localparam int DIV_STEPS = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic        neg;
        logic        ovf;
    } div_lane_t;

    typedef struct packed {
        logic           valid;
        logic           wzero;
        logic [63:0]    dvs;
        div_lane_t [2:0] lane;
    } div_stage_t;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    function automatic div_lane_t div_step(div_lane_t a, logic [63:0] d);
        div_lane_t  r;
        logic [64:0] t;
        logic [64:0] diff;
        r    = a;
        t    = {a.rem, a.num[31]};
        diff = t - {1'b0, d};
        r.num = {a.num[30:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            r.rem = diff[63:0];
            r.quo = {a.quo[30:0], 1'b1};
        end
        else
        begin
            r.rem = t[63:0];
            r.quo = {a.quo[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/vertex_transform_perspective_divide_core.sv =====
// pipeline: 3 transform stages, 32 divide steps and 1 output stage between input
// transfer and result; one item per cycle while not stalled, divider fully pipelined
// write items update the matrix at their transfer and give no result
// the whole pipeline holds while a result waits on tready
// rst_n clears all valid bits and loads the identity matrix
// depends on vtpd_pkg
module vertex_transform_perspective_divide_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // coef_index[3:0], coef_value[35:4], pos_x[67:36], pos_y[99:68], pos_z[131:100]
    input  logic [vtpd_pkg::IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [vtpd_pkg::OUT_DATA_W-1:0] m_tdata,
    // w_was_zero[0], saturated[1]
    output logic [1:0]                      m_tuser
);
    import vtpd_pkg::*;

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic adv;
    logic xfer;

    logic signed [31:0] matrix_reg [16];

    logic               s1_valid_reg;
    logic signed [63:0] prod_reg [12];
    logic signed [63:0] prod_next [12];
    logic signed [63:0] trans_reg [4];

    logic               s2_valid_reg;
    logic signed [65:0] comp_reg [4];

    logic               s3_valid_reg;
    logic               s3_wzero_reg;
    logic [63:0]        wmag_reg;
    logic [63:0]        nmag_reg [3];
    logic               neg_reg [3];

    div_stage_t         div_s0;
    div_stage_t         div_reg [1:DIV_STEPS];

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [1:0]            out_user_reg;
    logic                  sat_next;

    logic signed [31:0] pos [3];

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign xfer     = s_tvalid && adv;

    assign pos[0] = s_tdata[67:36];
    assign pos[1] = s_tdata[99:68];
    assign pos[2] = s_tdata[131:100];

    // coefficient writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                matrix_reg[i] <= (i % 5 == 0) ? ONE : 32'sd0;
        end
        else if (xfer && s_tuser == CMD_WRITE)
        begin
            matrix_reg[s_tdata[3:0]] <= s_tdata[35:4];
        end
    end

    // row r, column j product
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int j = 0; j < 4; j++)
                prod_next[r*4+j] = 64'(pos[r]) * 64'(matrix_reg[r*4+j]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= s_tvalid && s_tuser == CMD_POINT;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= div_reg[DIV_STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 12; i++)
                prod_reg[i] <= prod_next[i];
            for (int j = 0; j < 4; j++)
                trans_reg[j] <= 64'(matrix_reg[12+j]) <<< FRAC_BITS;
            for (int j = 0; j < 4; j++)
                comp_reg[j] <= 66'(prod_reg[j]) + 66'(prod_reg[4+j])
                             + 66'(prod_reg[8+j]) + 66'(trans_reg[j]);
        end
    end

    // w select and magnitudes
    logic signed [65:0] w_sel;
    logic               w_zero;
    logic signed [65:0] w_abs;
    logic signed [65:0] n_abs [3];

    always_comb
    begin
        w_zero = (comp_reg[3] == 66'sd0);
        w_sel  = w_zero ? (66'sd1 <<< (2 * FRAC_BITS)) : comp_reg[3];
        w_abs  = w_sel[65] ? -w_sel : w_sel;
        for (int c = 0; c < 3; c++)
            n_abs[c] = comp_reg[c][65] ? -comp_reg[c] : comp_reg[c];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_wzero_reg <= w_zero;
            wmag_reg     <= w_abs[63:0];
            for (int c = 0; c < 3; c++)
            begin
                nmag_reg[c] <= n_abs[c][63:0];
                neg_reg[c]  <= comp_reg[c][65] ^ w_sel[65];
            end
        end
    end

    // divider entry: upper numerator bits preload the remainder
    logic [64+FRAC_BITS-1:0] num_shift [3];

    always_comb
    begin
        div_s0.valid = s3_valid_reg;
        div_s0.wzero = s3_wzero_reg;
        div_s0.dvs   = wmag_reg;
        for (int c = 0; c < 3; c++)
        begin
            num_shift[c]       = {nmag_reg[c], {FRAC_BITS{1'b0}}};
            div_s0.lane[c].rem = 64'(num_shift[c] >> 32);
            div_s0.lane[c].num = num_shift[c][31:0];
            div_s0.lane[c].quo = 32'd0;
            div_s0.lane[c].neg = neg_reg[c];
            div_s0.lane[c].ovf = (64'(num_shift[c] >> 32) >= wmag_reg);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        div_stage_t st_in;
        if (k == 0)
        begin : g_first
            assign st_in = div_s0;
        end
        else
        begin : g_rest
            assign st_in = div_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_reg[k+1] <= '0;
            end
            else if (adv)
            begin
                div_reg[k+1].valid <= st_in.valid;
                div_reg[k+1].wzero <= st_in.wzero;
                div_reg[k+1].dvs   <= st_in.dvs;
                for (int c = 0; c < 3; c++)
                    div_reg[k+1].lane[c] <= div_step(st_in.lane[c], st_in.dvs);
            end
        end
    end

    // sign and saturation
    always_comb
    begin
        div_lane_t ln;
        sat_next      = 1'b0;
        out_data_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            ln = div_reg[DIV_STEPS].lane[c];
            if (ln.neg)
            begin
                if (ln.ovf || ln.quo > 32'h8000_0000)
                begin
                    sat_next = 1'b1;
                    out_data_next[c*32 +: 32] = 32'h8000_0000;
                end
                else
                begin
                    out_data_next[c*32 +: 32] = 32'd0 - ln.quo;
                end
            end
            else
            begin
                if (ln.ovf || ln.quo[31])
                begin
                    sat_next = 1'b1;
                    out_data_next[c*32 +: 32] = 32'h7FFF_FFFF;
                end
                else
                begin
                    out_data_next[c*32 +: 32] = ln.quo;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= {sat_next, div_reg[DIV_STEPS].wzero};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
